@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// SKTE_ASSERT checks a property on every rising clock edge outside reset.
// SKTE_ASSERT_ALWAYS checks a property on every rising clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define SKTE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sorted key table assertion failed");
`define SKTE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sorted key table assertion failed");
`else
`define SKTE_ASSERT(lbl, prop)
`define SKTE_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ rtl/skte_pkg.sv @@
`default_nettype none

package skte_pkg;

  localparam int KEY_W       = 32;
  localparam int PAY_PORT_W  = 32;
  localparam int COUNT_OUT_W = 7;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_SELECT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_UPDATE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_UPDATED   = 2'd3
  } status_t;

endpackage

`default_nettype wire

@@ rtl/sorted_key_table_engine_unit.sv @@
// Insert walks down from the top, moving each row with a larger key up one place, and
// then writes the new row. Keyed select, update and delete bisect, each probe a RAM
// read and a compare, and delete then moves one row per cycle. Select-all gives one
// row beat per cycle while the result side does not stall. One request at a time;
// the next is taken once the current one is finished.
// Reset (synchronous, rst_n low) empties the table and drops any pending result beat.
`default_nettype none

`include "assert_macros.svh"

module sorted_key_table_engine_unit #(
  parameter int DEPTH        = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] key, [63:32] payload
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [31:0] row_key, [63:32] row_payload,
                                       // [70:64] row_count, [71] zero
  output logic [2:0]       out_tuser,  // [1:0] status, [2] row_valid
  output logic             out_tlast   // last
);

  // Payload bits that are actually stored; the request port carries 32 bits.
  localparam int PW = (PAYLOAD_BITS < skte_pkg::PAY_PORT_W) ? PAYLOAD_BITS
                                                             : skte_pkg::PAY_PORT_W;
  localparam int RW = skte_pkg::KEY_W + PW;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // The sequencer. All states share the one RAM read port and the one key
  // comparator; the row being looked at is always the registered RAM output.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SCMP,
    ST_INS_SHIFT,
    ST_INS_PUT,
    ST_DEL_SHIFT,
    ST_LIST,
    ST_RESP
  } state_t;

  state_t state_r, state_nxt;

  skte_pkg::req_t  req_r, req_nxt;
  logic [31:0]     key_r, key_nxt;
  logic [PW-1:0]   pay_r, pay_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   bottom_r, bottom_nxt;
  logic [CW-1:0]   hi_r, hi_nxt;
  logic [CW-1:0]   rows_r, rows_nxt;

  // Single-beat result waiting for the output register.
  skte_pkg::status_t res_status_r, res_status_nxt;
  logic              res_valid_r, res_valid_nxt;
  logic [31:0]       res_key_r, res_key_nxt;
  logic [PW-1:0]     res_pay_r, res_pay_nxt;

  // Output register; it lets the sequencer move on while a beat waits.
  logic              out_valid_r, out_valid_nxt;
  skte_pkg::status_t out_status_r, out_status_nxt;
  logic              out_rvalid_r, out_rvalid_nxt;
  logic [31:0]       out_key_r, out_key_nxt;
  logic [PW-1:0]     out_pay_r, out_pay_nxt;
  logic              out_last_r, out_last_nxt;
  logic [CW-1:0]     out_count_r, out_count_nxt;

  // RAM port signals. A row is stored as {key, payload}.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [RW-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [RW-1:0] rd_data;

  logic [31:0]   rd_key;
  logic [PW-1:0] rd_pay;
  logic          key_eq;
  logic          key_gt;
  logic [CW-1:0] mid_full;
  logic [AW-1:0] mid;
  logic [CW-1:0] idx_ext;
  logic          slot_free;
  logic          list_last;

  skte_pkg::req_t in_req;
  logic [31:0]    in_key;
  logic [PW-1:0]  in_pay;

  skte_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_rows (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_req = skte_pkg::req_t'(in_tuser[1:0]);
  assign in_key = in_tdata[31:0];
  assign in_pay = in_tdata[32 +: PW];

  assign rd_key = rd_data[RW-1:PW];
  assign rd_pay = rd_data[PW-1:0];

  // The shared comparator: the row just read against the request key.
  assign key_eq = (rd_key == key_r);
  assign key_gt = (rd_key > key_r);

  // Bisection midpoint, bottom + (top - bottom) / 2 with top = hi - 1.
  assign mid_full = bottom_r + ((hi_r - bottom_r - 1'b1) >> 1);
  assign mid      = mid_full[AW-1:0];

  assign idx_ext   = CW'(idx_r);
  assign slot_free = !out_valid_r || out_tready;
  assign list_last = ((idx_ext + 1'b1) == rows_r);

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    idx_nxt        = idx_r;
    bottom_nxt     = bottom_r;
    hi_nxt         = hi_r;
    rows_nxt       = rows_r;
    res_status_nxt = res_status_r;
    res_valid_nxt  = res_valid_r;
    res_key_nxt    = res_key_r;
    res_pay_nxt    = res_pay_r;

    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_rvalid_nxt = out_rvalid_r;
    out_key_nxt    = out_key_r;
    out_pay_nxt    = out_pay_r;
    out_last_nxt   = out_last_r;
    out_count_nxt  = out_count_r;

    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = {key_r, pay_r};
    rd_addr = idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          req_nxt        = in_req;
          key_nxt        = in_key;
          pay_nxt        = in_pay;
          res_status_nxt = skte_pkg::STAT_OK;
          res_valid_nxt  = 1'b0;
          res_key_nxt    = '0;
          res_pay_nxt    = '0;
          bottom_nxt     = '0;
          hi_nxt         = rows_r;
          case (in_req)
            skte_pkg::REQ_INSERT: begin
              if (rows_r == CW'(DEPTH)) begin
                res_status_nxt = skte_pkg::STAT_FULL;
                state_nxt      = ST_RESP;
              end else if (rows_r == '0) begin
                idx_nxt   = '0;
                state_nxt = ST_INS_PUT;
              end else begin
                // Walk down from the top, starting with the highest row held.
                idx_nxt   = rows_r[AW-1:0];
                rd_addr   = AW'(rows_r - 1'b1);
                state_nxt = ST_INS_SHIFT;
              end
            end
            skte_pkg::REQ_SELECT: begin
              if (in_key != '0) begin
                state_nxt = ST_SRCH;
              end else if (rows_r == '0) begin
                state_nxt = ST_RESP;
              end else begin
                idx_nxt   = '0;
                rd_addr   = '0;
                state_nxt = ST_LIST;
              end
            end
            default: begin
              state_nxt = ST_SRCH;
            end
          endcase
        end
      end

      ST_SRCH: begin
        if (bottom_r < hi_r) begin
          idx_nxt   = mid;
          rd_addr   = mid;
          state_nxt = ST_SCMP;
        end else begin
          res_status_nxt = skte_pkg::STAT_NOT_FOUND;
          state_nxt      = ST_RESP;
        end
      end

      ST_SCMP: begin
        if (key_eq) begin
          case (req_r)
            skte_pkg::REQ_SELECT: begin
              res_valid_nxt = 1'b1;
              res_key_nxt   = rd_key;
              res_pay_nxt   = rd_pay;
              state_nxt     = ST_RESP;
            end
            skte_pkg::REQ_UPDATE: begin
              wr_en          = 1'b1;
              wr_data        = {rd_key, pay_r};
              res_status_nxt = skte_pkg::STAT_UPDATED;
              state_nxt      = ST_RESP;
            end
            skte_pkg::REQ_DELETE: begin
              if ((idx_ext + 1'b1) < rows_r) begin
                rd_addr   = idx_r + 1'b1;
                state_nxt = ST_DEL_SHIFT;
              end else begin
                rows_nxt  = rows_r - 1'b1;
                state_nxt = ST_RESP;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end else begin
          if (key_gt) begin
            hi_nxt = idx_ext;
          end else begin
            bottom_nxt = idx_ext + 1'b1;
          end
          state_nxt = ST_SRCH;
        end
      end

      ST_INS_SHIFT: begin
        // rd_data holds row idx_r - 1.
        if (key_gt) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          idx_nxt = idx_r - 1'b1;
          if (idx_r == AW'(1)) begin
            state_nxt = ST_INS_PUT;
          end else begin
            rd_addr = idx_r - AW'(2);
          end
        end else begin
          wr_en     = 1'b1;
          rows_nxt  = rows_r + 1'b1;
          state_nxt = ST_RESP;
        end
      end

      ST_INS_PUT: begin
        wr_en     = 1'b1;
        rows_nxt  = rows_r + 1'b1;
        state_nxt = ST_RESP;
      end

      ST_DEL_SHIFT: begin
        // rd_data holds row idx_r + 1; move it down one place.
        wr_en   = 1'b1;
        wr_data = rd_data;
        idx_nxt = idx_r + 1'b1;
        if ((idx_ext + CW'(2)) < rows_r) begin
          rd_addr = AW'(idx_ext + CW'(2));
        end else begin
          rows_nxt  = rows_r - 1'b1;
          state_nxt = ST_RESP;
        end
      end

      ST_LIST: begin
        // rd_data holds row idx_r; re-read it while the output is stalled.
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = skte_pkg::STAT_OK;
          out_rvalid_nxt = 1'b1;
          out_key_nxt    = rd_key;
          out_pay_nxt    = rd_pay;
          out_last_nxt   = list_last;
          out_count_nxt  = rows_r;
          if (list_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
            rd_addr = idx_r + 1'b1;
          end
        end
      end

      ST_RESP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_rvalid_nxt = res_valid_r;
          out_key_nxt    = res_key_r;
          out_pay_nxt    = res_pay_r;
          out_last_nxt   = 1'b1;
          out_count_nxt  = rows_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rows_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    pay_r        <= pay_nxt;
    idx_r        <= idx_nxt;
    bottom_r     <= bottom_nxt;
    hi_r         <= hi_nxt;
    res_status_r <= res_status_nxt;
    res_valid_r  <= res_valid_nxt;
    res_key_r    <= res_key_nxt;
    res_pay_r    <= res_pay_nxt;
    out_status_r <= out_status_nxt;
    out_rvalid_r <= out_rvalid_nxt;
    out_key_r    <= out_key_nxt;
    out_pay_r    <= out_pay_nxt;
    out_last_r   <= out_last_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, skte_pkg::COUNT_OUT_W'(out_count_r),
                       skte_pkg::PAY_PORT_W'(out_pay_r), out_key_r};
  assign out_tuser  = {out_rvalid_r, out_status_r};
  assign out_tlast  = out_last_r;

  // The table never holds more rows than it has room for.
  `SKTE_ASSERT(a_rows_in_range, rows_r <= CW'(DEPTH))
  // Each request adds or removes at most one row.
  `SKTE_ASSERT(a_rows_step, (rows_r == $past(rows_r)) ||
      (rows_r == $past(rows_r) + 1'b1) || (rows_r + 1'b1 == $past(rows_r)))
  // The bisection window never inverts.
  `SKTE_ASSERT(a_window_ok, (state_r == ST_SRCH) |-> (bottom_r <= hi_r))
  // A full listing only runs over a table that holds rows.
  `SKTE_ASSERT(a_list_nonempty, (state_r == ST_LIST) |-> (rows_r != '0))
  // The table is only written while a request is in progress.
  `SKTE_ASSERT(a_no_idle_write, (state_r == ST_IDLE) |-> !wr_en)

endmodule

`default_nettype wire

@@ rtl/skte_ram.sv @@
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module skte_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ dv/table_result_checker.sv @@
`default_nettype none

// Watches the request and result channels of the sorted key table, keeps its
// own copy of the table, and compares every result beat with the oldest
// expected beat.
module table_result_checker
  import skte_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [63:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [71:0] out_tdata,
  input  wire logic [2:0]  out_tuser,
  input  wire logic        out_tlast,
  output int               mismatch_count,
  output int               pending_count
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t     status;
    logic        row_valid;
    logic [31:0] row_key;
    logic [31:0] row_payload;
    logic        last;
    logic [6:0]  row_count;
  } table_beat_t;

  table_beat_t expected_beats[$];

  logic [31:0] key_col [DEPTH];
  logic [31:0] pay_col [DEPTH];
  int          rows_now;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("time %0t: %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic void push_beat(status_t st, logic valid, logic [31:0] k,
                                    logic [31:0] p, logic last);
    table_beat_t b;
    b.status      = st;
    b.row_valid   = valid;
    b.row_key     = k;
    b.row_payload = p;
    b.last        = last;
    b.row_count   = 7'(rows_now);
    expected_beats.push_back(b);
  endfunction

  // Exact bisection over the occupied rows; with repeated keys the probe
  // order decides which copy is found.
  function automatic int bisect_row(logic [31:0] k);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = rows_now - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (key_col[mid] == k) return mid;
      if (key_col[mid] < k) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  function automatic void apply_request(req_t rq, logic [31:0] k, logic [31:0] p);
    int idx;
    int i;
    case (rq)
      REQ_INSERT: begin
        if (rows_now >= DEPTH) begin
          push_beat(STAT_FULL, 1'b0, '0, '0, 1'b1);
        end else begin
          // New row lands after every row whose key is not larger.
          i = rows_now;
          while (i > 0 && key_col[i-1] > k) begin
            key_col[i] = key_col[i-1];
            pay_col[i] = pay_col[i-1];
            i--;
          end
          key_col[i] = k;
          pay_col[i] = p;
          rows_now++;
          push_beat(STAT_OK, 1'b0, '0, '0, 1'b1);
        end
      end
      REQ_SELECT: begin
        if (k != '0) begin
          idx = bisect_row(k);
          if (idx < 0) push_beat(STAT_NOT_FOUND, 1'b0, '0, '0, 1'b1);
          else push_beat(STAT_OK, 1'b1, key_col[idx], pay_col[idx], 1'b1);
        end else if (rows_now == 0) begin
          push_beat(STAT_OK, 1'b0, '0, '0, 1'b1);
        end else begin
          for (i = 0; i < rows_now; i++) begin
            push_beat(STAT_OK, 1'b1, key_col[i], pay_col[i], i + 1 == rows_now);
          end
        end
      end
      REQ_DELETE: begin
        idx = bisect_row(k);
        if (idx < 0) begin
          push_beat(STAT_NOT_FOUND, 1'b0, '0, '0, 1'b1);
        end else begin
          for (i = idx; i + 1 < rows_now; i++) begin
            key_col[i] = key_col[i+1];
            pay_col[i] = pay_col[i+1];
          end
          rows_now--;
          push_beat(STAT_OK, 1'b0, '0, '0, 1'b1);
        end
      end
      default: begin
        idx = bisect_row(k);
        if (idx < 0) begin
          push_beat(STAT_NOT_FOUND, 1'b0, '0, '0, 1'b1);
        end else begin
          pay_col[idx] = p;
          push_beat(STAT_UPDATED, 1'b0, '0, '0, 1'b1);
        end
      end
    endcase
  endfunction

  task automatic check_beat();
    table_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch("result beat with no request outstanding", out_tdata[31:0], '0);
    end else begin
      want = expected_beats.pop_front();
      if (out_tuser[1:0] != want.status)
        report_mismatch("status", 32'(out_tuser[1:0]), 32'(want.status));
      if (out_tuser[2] != want.row_valid)
        report_mismatch("row_valid", 32'(out_tuser[2]), 32'(want.row_valid));
      if (out_tdata[31:0] != want.row_key)
        report_mismatch("row_key", out_tdata[31:0], want.row_key);
      if (out_tdata[63:32] != want.row_payload)
        report_mismatch("row_payload", out_tdata[63:32], want.row_payload);
      if (out_tdata[70:64] != want.row_count)
        report_mismatch("row_count", 32'(out_tdata[70:64]), 32'(want.row_count));
      if (out_tdata[71] != 1'b0)
        report_mismatch("pad bit", 32'(out_tdata[71]), '0);
      if (out_tlast != want.last)
        report_mismatch("last", 32'(out_tlast), 32'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rows_now       = 0;
      mismatch_count = 0;
      expected_beats.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        apply_request(req_t'(in_tuser), in_tdata[31:0], in_tdata[63:32]);
      end
      if (out_tvalid && out_tready) begin
        check_beat();
      end
    end
    pending_count = expected_beats.size();
  end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none

// Top of the sorted key table bench. This module only makes stimulus and
// gives the verdict; the checker beside the block predicts every result beat
// and counts mismatches.
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import skte_pkg::*;

  localparam int DEPTH        = 64;
  localparam int PHASE_ITEMS  = 140;        // random requests per idling phase
  localparam int GROW_ITEMS   = 110;        // insert-heavy stretch of the random stream
  localparam int SHRINK_ITEMS = 60;         // delete-heavy stretch that follows
  localparam int HOLD_CYCLES  = 300;        // long receiver hold-off
  localparam int DRAIN_CYCLES = 100;        // longest request is a delete of ~DEPTH rows
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int POOL_SIZE    = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  int          mismatch_count;
  int          pending_count;

  // Idle rates in percent for each side, and the one-shot receiver hold-off.
  int unsigned tx_idle_pct = 30;
  int unsigned rx_idle_pct = 58;
  logic        hold_request = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  logic [31:0] key_pool [POOL_SIZE];

  always #1 clk = ~clk;

  sorted_key_table_engine_unit #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (32)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [31:0] key, [63:32] payload
    .in_tuser   (in_tuser),     // [1:0] req_type
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // [31:0] row_key, [63:32] row_payload, [70:64] row_count
    .out_tuser  (out_tuser),    // [1:0] status, [2] row_valid
    .out_tlast  (out_tlast)
  );

  table_result_checker #(
    .DEPTH (DEPTH)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // Result side. Each falling edge decides whether the next edge takes a
  // beat. When the stimulus asks for it, ready is held low for a long stretch
  // exactly once, so that results back up and the block stops taking
  // requests while the sender keeps offering them.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_request && !hold_taken) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: a hung block or a lost result beat ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Offers one request beat from a falling edge and returns at the falling
  // edge after it was taken. Random gaps come first; valid stays high from
  // one beat to the next when no gap is drawn.
  task automatic send_request(input req_t rq, input logic [31:0] k,
                              input logic [31:0] p);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= rq;
    in_tdata  <= {p, k};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Keys mostly come from a small pool so that inserts repeat keys and
  // selects, updates and deletes hit; the rest are fully random.
  function automatic logic [31:0] pick_key();
    if ($urandom_range(99) < 75) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom();
  endfunction

  // The random stream alternates between a stretch that fills the table past
  // full and a stretch that mostly deletes rows.
  function automatic req_t pick_request(bit growing);
    int unsigned r;
    r = $urandom_range(99);
    if (growing) begin
      if (r < 75) return REQ_INSERT;
      if (r < 85) return REQ_SELECT;
      if (r < 95) return REQ_UPDATE;
      return REQ_DELETE;
    end
    if (r < 60) return REQ_DELETE;
    if (r < 70) return REQ_INSERT;
    if (r < 85) return REQ_SELECT;
    return REQ_UPDATE;
  endfunction

  initial begin
    int   item;
    int   ph;
    bit   growing;
    req_t rq;

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'h0000_0001;
    key_pool[2] = 32'hFFFF_FFFF;
    key_pool[3] = 32'h7FFF_FFFF;
    key_pool[4] = 32'h8000_0000;
    for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = $urandom();

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: empty table, key zero as a stored key, extreme keys and
    // payloads, repeated keys, list-all, and misses of every keyed request.
    send_request(REQ_SELECT, 32'h0, 32'h0);                  // list-all of an empty table
    send_request(REQ_SELECT, 32'h5, 32'h0);
    send_request(REQ_DELETE, 32'h5, 32'h0);
    send_request(REQ_UPDATE, 32'h5, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 32'h0, 32'h0);                  // key zero is a normal row
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 32'h8000_0000, 32'hAAAA_AAAA);
    send_request(REQ_INSERT, 32'h8000_0000, 32'h5555_5555);  // lands after its equal
    send_request(REQ_INSERT, 32'h8000_0000, 32'h1234_5678);
    send_request(REQ_INSERT, 32'h1, 32'h1);
    send_request(REQ_SELECT, 32'h0, 32'h0);                  // lists all six rows
    send_request(REQ_SELECT, 32'h8000_0000, 32'h0);          // bisection picks a copy
    send_request(REQ_SELECT, 32'hFFFF_FFFF, 32'h0);
    send_request(REQ_SELECT, 32'h2, 32'h0);
    send_request(REQ_UPDATE, 32'h0, 32'hFFFF_FFFF);
    send_request(REQ_UPDATE, 32'h8000_0000, 32'h0);
    send_request(REQ_DELETE, 32'h0, 32'h0);
    send_request(REQ_DELETE, 32'h8000_0000, 32'h0);
    send_request(REQ_SELECT, 32'h0, 32'h0);
    send_request(REQ_DELETE, 32'hFFFF_FFFF, 32'h0);
    send_request(REQ_DELETE, 32'h1, 32'h0);
    send_request(REQ_DELETE, 32'h7, 32'h0);
    send_request(REQ_SELECT, 32'h0, 32'h0);

    // Random part in three idling phases: sender idles less than the
    // receiver, then the reverse, then neither idles. The last phase opens
    // with the long receiver hold-off.
    item = 0;
    for (ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        tx_idle_pct <= 58;
        rx_idle_pct <= 30;
      end else if (ph == 2) begin
        tx_idle_pct  <= 0;
        rx_idle_pct  <= 0;
        hold_request <= 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        growing = (item % (GROW_ITEMS + SHRINK_ITEMS)) < GROW_ITEMS;
        rq = pick_request(growing);
        send_request(rq, pick_key(), $urandom());
        item++;
      end
    end
    in_tvalid <= 1'b0;

    // Drain: every request has at least one result, so an empty store of
    // expected beats means the block is done; then give stray beats a chance.
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
